FILE: sv/sfp_pkg.sv
// Shared types and constants for the serial frame parser.
// Used by sfp_ctrl, sfp_datapath and serial_frame_parser_unit; no dependencies.
package sfp_pkg;

	// Configuration register map
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd1;

	localparam logic [7:0] START_MARKER_RST = 8'hAA;
	localparam logic [7:0] END_MARKER_RST   = 8'h55;

	// Header bytes before the payload (start, id, cmd, length)
	localparam int FRAME_OVERHEAD = 4;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic take_id;
		logic take_cmd;
		logic take_len;
		logic take_data;
		logic take_csum;
		logic emit_empty;
		logic rd_start;
		logic rd_issue;
		logic rd_load;
	} sfp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_start;
		logic end_ok;
		logic len_over;
		logic len_zero;
		logic frame_empty;
		logic data_last;
		logic rd_last;
	} sfp_status_t;

endpackage

FILE: sv/sfp_datapath.sv
// Datapath of the serial frame parser: markers, header fields, checksum,
// payload memory and result register. Depends on sfp_pkg.
module sfp_datapath import sfp_pkg::*; #(
	parameter int FRAME_BUFFER_BYTES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	// received byte
	input  logic [7:0]           rx_byte,
	// control
	input  sfp_cmd_t             cmd,
	output sfp_status_t          status,
	// result fields
	output logic [7:0]           node_id,
	output logic [7:0]           command_code,
	output logic [5:0]           payload_length,
	output logic [7:0]           payload_byte,
	output logic                 payload_valid,
	output logic                 last_of_frame
);

	localparam int CAP    = FRAME_BUFFER_BYTES - FRAME_OVERHEAD - 2;
	localparam int CNT_W  = $clog2(CAP + 1);
	localparam int ADDR_W = (CAP > 1) ? $clog2(CAP) : 1;
	localparam logic [7:0] CAP_B = 8'(CAP);

	logic [7:0]       start_marker_q;
	logic [7:0]       end_marker_q;
	logic [7:0]       id_q;
	logic [7:0]       cmd_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [7:0]       xor_q;
	logic [7:0]       csum_q;
	logic [7:0]       mem [CAP];
	logic [7:0]       rd_data_s1;
	logic             rd_last_s1;
	logic [7:0]       out_id_q;
	logic [7:0]       out_cmd_q;
	logic [5:0]       out_len_q;
	logic [7:0]       out_byte_q;
	logic             out_pv_q;
	logic             out_last_q;
	logic [7:0]       len_ext;

	// Marker registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_START_MARKER) begin
				start_marker_q <= cfg_data;
			end else if (cfg_index == REG_END_MARKER) begin
				end_marker_q <= cfg_data;
			end
		end
	end

	// Header fields, byte counter and running checksum
	always_ff @(posedge clk) begin
		if (cmd.take_id) begin
			id_q  <= rx_byte;
			xor_q <= rx_byte;
		end
		if (cmd.take_cmd) begin
			cmd_q <= rx_byte;
			xor_q <= xor_q ^ rx_byte;
		end
		if (cmd.take_len) begin
			len_q <= CNT_W'(rx_byte);
			cnt_q <= '0;
			xor_q <= xor_q ^ rx_byte;
		end
		if (cmd.take_data) begin
			cnt_q <= CNT_W'(cnt_q + 1'b1);
			xor_q <= xor_q ^ rx_byte;
		end
		if (cmd.take_csum) begin
			csum_q <= rx_byte;
		end
	end

	// Payload memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.take_data) begin
			mem[cnt_q[ADDR_W-1:0]] <= rx_byte;
		end
		if (cmd.rd_issue) begin
			rd_data_s1 <= mem[rd_idx_q[ADDR_W-1:0]];
			rd_last_s1 <= status.rd_last;
		end
	end

	// Readout index
	always_ff @(posedge clk) begin
		if (cmd.rd_start) begin
			rd_idx_q <= '0;
		end else if (cmd.rd_issue) begin
			rd_idx_q <= CNT_W'(rd_idx_q + 1'b1);
		end
	end

	// Result register
	assign len_ext = 8'(len_q);

	always_ff @(posedge clk) begin
		if (cmd.rd_load || cmd.emit_empty) begin
			out_id_q  <= id_q;
			out_cmd_q <= cmd_q;
			out_len_q <= len_ext[5:0];
		end
		if (cmd.rd_load) begin
			out_byte_q <= rd_data_s1;
			out_pv_q   <= 1'b1;
			out_last_q <= rd_last_s1;
		end else if (cmd.emit_empty) begin
			out_byte_q <= 8'h00;
			out_pv_q   <= 1'b0;
			out_last_q <= 1'b1;
		end
	end

	// Status toward the controller
	always_comb begin
		status.is_start    = (rx_byte == start_marker_q);
		status.end_ok      = (rx_byte == end_marker_q) && (xor_q == csum_q);
		status.len_over    = (rx_byte > CAP_B);
		status.len_zero    = (rx_byte == 8'h00);
		status.frame_empty = (len_q == '0);
		status.data_last   = (CNT_W'(cnt_q + 1'b1) == len_q);
		status.rd_last     = (CNT_W'(rd_idx_q + 1'b1) == len_q);
	end

	assign node_id        = out_id_q;
	assign command_code   = out_cmd_q;
	assign payload_length = out_len_q;
	assign payload_byte   = out_byte_q;
	assign payload_valid  = out_pv_q;
	assign last_of_frame  = out_last_q;

endmodule

FILE: sv/sfp_ctrl.sv
// Controller of the serial frame parser: frame phase sequencer, readout
// control and result handshake. Depends on sfp_pkg.
module sfp_ctrl import sfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	input  sfp_status_t status,
	output sfp_cmd_t    cmd
);

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_ID   = 3'd1;
	localparam logic [2:0] PH_CMD  = 3'd2;
	localparam logic [2:0] PH_LEN  = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;
	localparam logic [2:0] PH_CSUM = 3'd5;
	localparam logic [2:0] PH_END  = 3'd6;
	localparam logic [2:0] PH_OUT  = 3'd7;

	logic [2:0] phase_q;
	logic [2:0] phase_d;
	logic       out_valid_q;
	logic       rd_pend_q;
	logic       in_acc;
	logic       out_acc;

	// Input held off during readout, and at the end byte until the result slot drains
	always_comb begin
		unique case (phase_q)
			PH_OUT:  in_stall = 1'b1;
			PH_END:  in_stall = out_valid_q;
			default: in_stall = 1'b0;
		endcase
	end

	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;

	// Phase sequencing and datapath commands
	always_comb begin
		phase_d = phase_q;
		cmd     = '0;
		cmd.rd_load = rd_pend_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (in_acc && status.is_start) begin
					phase_d = PH_ID;
				end
			end
			PH_ID: begin
				if (in_acc) begin
					cmd.take_id = 1'b1;
					phase_d     = PH_CMD;
				end
			end
			PH_CMD: begin
				if (in_acc) begin
					cmd.take_cmd = 1'b1;
					phase_d      = PH_LEN;
				end
			end
			PH_LEN: begin
				if (in_acc) begin
					priority if (status.len_over) begin
						phase_d = PH_HUNT;
					end else if (status.len_zero) begin
						cmd.take_len = 1'b1;
						phase_d      = PH_CSUM;
					end else begin
						cmd.take_len = 1'b1;
						phase_d      = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				if (in_acc) begin
					cmd.take_data = 1'b1;
					if (status.data_last) begin
						phase_d = PH_CSUM;
					end
				end
			end
			PH_CSUM: begin
				if (in_acc) begin
					cmd.take_csum = 1'b1;
					phase_d       = PH_END;
				end
			end
			PH_END: begin
				// good frame: empty result at once, or start the readout
				if (in_acc) begin
					phase_d = PH_HUNT;
					if (status.end_ok) begin
						if (status.frame_empty) begin
							cmd.emit_empty = 1'b1;
						end else begin
							cmd.rd_start = 1'b1;
							phase_d      = PH_OUT;
						end
					end
				end
			end
			PH_OUT: begin
				if (!rd_pend_q && (!out_valid_q || out_acc)) begin
					cmd.rd_issue = 1'b1;
					if (status.rd_last) begin
						phase_d = PH_HUNT;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			out_valid_q <= 1'b0;
			rd_pend_q   <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			rd_pend_q <= cmd.rd_issue;
			if (cmd.rd_load || cmd.emit_empty) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/serial_frame_parser_unit.sv
// Top level of the serial frame parser: controller plus datapath.
// Depends on sfp_pkg, sfp_ctrl and sfp_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall, rx_byte): one received byte per request.
//   A frame is start marker, slave id, command, length, payload, checksum, end
//   marker. The checksum is the XOR of id, command, length and payload.
//   Output channel (out_valid / out_stall): one request per payload byte of a
//   good frame, or a single request with payload_valid low for an empty
//   payload; last_of_frame marks the final one.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 is
//   the start marker, index 1 the end marker; other indexes are ignored.
//   cfg_ready is always high.
// Timing:
//   Bytes are taken while in_stall is low. After a good end marker
//   carrying payload bytes, the payload is read back from the frame buffer
//   memory, each result passing the memory read stage, then the result
//   register, and no new read starts while one is pending; an empty-payload
//   result is valid from the edge that takes the end byte.
//   in_stall is high during readout after the end byte, which receiver stalls
//   prolong, and at the end byte while the result register still holds an
//   untaken result.
//   A stalled receiver holds the result register and pauses readout.
// Reset: markers return to 0xAA / 0x55, the parser hunts, no result pending.
module serial_frame_parser_unit import sfp_pkg::*; #(
	parameter int FRAME_BUFFER_BYTES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           node_id,
	output logic [7:0]           command_code,
	output logic [5:0]           payload_length,
	output logic [7:0]           payload_byte,
	output logic                 payload_valid,
	output logic                 last_of_frame,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	sfp_cmd_t    cmd;
	sfp_status_t status;

	assign cfg_ready = 1'b1;

	sfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	sfp_datapath #(
		.FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.rx_byte        (rx_byte),
		.cmd            (cmd),
		.status         (status),
		.node_id        (node_id),
		.command_code   (command_code),
		.payload_length (payload_length),
		.payload_byte   (payload_byte),
		.payload_valid  (payload_valid),
		.last_of_frame  (last_of_frame)
	);

endmodule
